@@ rtl/core/dslr_pkg.sv @@
// Shared types and constants for the display serial link register block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package dslr_pkg;

    // Word and field widths.
    localparam int DATA_W         = 32;
    localparam int OFFSET_W       = 10;
    localparam int APERTURE_BYTES = 1024;
    localparam int RAM_DEPTH      = APERTURE_BYTES / 4;
    localparam int WORD_ADDR_W    = $clog2(RAM_DEPTH);
    localparam int PROTOCOL_WORDS = 128;
    localparam int SUB_WORDS      = 64;

    // Access kinds.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Region starts within the aperture.
    localparam logic [OFFSET_W-1:0] PHY_START = 10'h200;
    localparam logic [OFFSET_W-1:0] PLL_START = 10'h300;

    // Byte offsets of the words with special behavior.
    localparam logic [OFFSET_W-1:0] OFF_REVISION   = 10'h000;
    localparam logic [OFFSET_W-1:0] OFF_SYSCONFIG  = 10'h010;
    localparam logic [OFFSET_W-1:0] OFF_SYSSTATUS  = 10'h014;
    localparam logic [OFFSET_W-1:0] OFF_IRQSTATUS  = 10'h018;
    localparam logic [OFFSET_W-1:0] OFF_CLKCTRL    = 10'h054;
    localparam logic [OFFSET_W-1:0] OFF_PLL_STATUS = PLL_START + 10'h004;
    localparam logic [OFFSET_W-1:0] OFF_PLL_GO     = PLL_START + 10'h008;

    // Word index and reset value of the system status word.
    localparam logic [WORD_ADDR_W-1:0] SYSSTATUS_IDX   = OFF_SYSSTATUS[OFFSET_W-1:2];
    localparam logic [DATA_W-1:0]      SYSSTATUS_RESET = 32'h0000_0001;

    // Bit masks.
    localparam logic [DATA_W-1:0] SOFT_RESET_MASK = 32'h0000_0002;

    // Controller states.
    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } dslr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic capture;
        logic commit;
    } dslr_cmd_t;

endpackage

@@ rtl/core/dslr_if.sv @@
// Valid/ready channel interfaces for request and response words.
// Depends on dslr_pkg for field widths.
interface dslr_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [dslr_pkg::OFFSET_W-1:0] byte_offset;
    logic [dslr_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output req_type, output byte_offset, output write_data,
                    input ready);
    modport sink (input valid, input req_type, input byte_offset, input write_data,
                  output ready);
endinterface

interface dslr_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [dslr_pkg::DATA_W-1:0] read_data;
    logic                        misaligned;

    modport source (output valid, output read_data, output misaligned, input ready);
    modport sink (input valid, input read_data, input misaligned, output ready);
endinterface

@@ rtl/core/dslr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module dslr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/dslr_ctrl.sv @@
// Controller state machine: accepts a request word, waits for the RAM read,
// then commits the access into the output register. Depends on dslr_pkg.
module dslr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output dslr_pkg::dslr_cmd_t cmd
);
    import dslr_pkg::*;

    dslr_state_t state_reg;
    dslr_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        slot_free;

    // State and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The output register can take a new result when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid is set by a commit and cleared when the word is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    // A captured request always moves on to the execute state.
    a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_EXEC)
        else $error("capture did not enter execute state");

    // A commit always leaves a result waiting in the output register.
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not raise output valid");

    // A blocked execute waits without losing the request.
    a_exec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && !slot_free) |=> state_reg == ST_EXEC)
        else $error("execute left while output slot was busy");

endmodule

@@ rtl/core/dslr_datapath.sv @@
// Datapath: request registers, the aperture RAM with per-word valid bits,
// the PLL flags and the result register. Depends on dslr_pkg and dslr_ram.
module dslr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dslr_pkg::dslr_cmd_t           cmd,
    input  logic                          req_type,
    input  logic [dslr_pkg::OFFSET_W-1:0] byte_offset,
    input  logic [dslr_pkg::DATA_W-1:0]   write_data,
    output logic [dslr_pkg::DATA_W-1:0]   read_data,
    output logic                          misaligned
);
    import dslr_pkg::*;

    logic                   req_type_reg;
    logic [OFFSET_W-1:0]    req_off_reg;
    logic [DATA_W-1:0]      req_data_reg;
    logic [RAM_DEPTH-1:0]   valid_reg;
    logic                   pwr_on_reg;
    logic                   lock_reg;
    logic [DATA_W-1:0]      read_data_reg;
    logic                   misaligned_reg;

    logic [WORD_ADDR_W-1:0] idx;
    logic [DATA_W-1:0]      ram_rd_data;
    logic [DATA_W-1:0]      stored_word;
    logic                   is_misaligned;
    logic                   wr_en;
    logic [DATA_W-1:0]      wr_word;
    logic [DATA_W-1:0]      rd_word;
    logic                   lock_set;
    logic                   pwr_wr;

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= req_type;
            req_off_reg  <= byte_offset;
            req_data_reg <= write_data;
        end
    end

    // One RAM covers all three regions, indexed by the word address.
    dslr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (cmd.commit && wr_en),
        .wr_addr (idx),
        .wr_data (wr_word),
        .rd_en   (cmd.capture),
        .rd_addr (byte_offset[OFFSET_W-1:2]),
        .rd_data (ram_rd_data)
    );

    assign idx           = req_off_reg[OFFSET_W-1:2];
    assign is_misaligned = req_off_reg[1:0] != 2'b00;

    // A word never written reads as its reset value.
    always_comb
    begin
        if (valid_reg[idx])
        begin
            stored_word = ram_rd_data;
        end
        else if (idx == SYSSTATUS_IDX)
        begin
            stored_word = SYSSTATUS_RESET;
        end
        else
        begin
            stored_word = '0;
        end
    end

    // Access decode: read value, store value and side effects.
    always_comb
    begin
        wr_en    = 1'b0;
        wr_word  = req_data_reg;
        rd_word  = '0;
        lock_set = 1'b0;
        pwr_wr   = 1'b0;
        if (!is_misaligned)
        begin
            if (req_type_reg == REQ_WRITE)
            begin
                if (req_off_reg < PHY_START)
                begin
                    if (req_off_reg == OFF_REVISION || req_off_reg == OFF_SYSSTATUS)
                    begin
                        wr_en = 1'b0;
                    end
                    else if (req_off_reg == OFF_SYSCONFIG)
                    begin
                        wr_en   = 1'b1;
                        wr_word = req_data_reg & ~SOFT_RESET_MASK;
                    end
                    else if (req_off_reg == OFF_IRQSTATUS)
                    begin
                        wr_en   = 1'b1;
                        wr_word = stored_word & ~req_data_reg;
                    end
                    else if (req_off_reg == OFF_CLKCTRL)
                    begin
                        wr_en   = 1'b1;
                        pwr_wr  = 1'b1;
                        wr_word = {req_data_reg[31:30], req_data_reg[31:30],
                                   req_data_reg[27:0]};
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                end
                else if (req_off_reg < PLL_START)
                begin
                    wr_en = 1'b1;
                end
                else if (req_off_reg == OFF_PLL_STATUS)
                begin
                    wr_en = 1'b0;
                end
                else if (req_off_reg == OFF_PLL_GO)
                begin
                    lock_set = req_data_reg[0];
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
            else
            begin
                if (req_off_reg == OFF_PLL_STATUS)
                begin
                    rd_word = {{(DATA_W-2){1'b0}}, lock_reg, pwr_on_reg};
                end
                else if (req_off_reg == OFF_PLL_GO)
                begin
                    rd_word = '0;
                end
                else
                begin
                    rd_word = stored_word;
                end
            end
        end
    end

    // Valid bits and PLL flags; reset returns every word to its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            pwr_on_reg <= 1'b0;
            lock_reg   <= 1'b0;
        end
        else if (cmd.commit)
        begin
            if (wr_en)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (pwr_wr)
            begin
                pwr_on_reg <= |req_data_reg[31:30];
            end
            if (lock_set)
            begin
                lock_reg <= 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            read_data_reg  <= rd_word;
            misaligned_reg <= is_misaligned;
        end
    end

    assign read_data  = read_data_reg;
    assign misaligned = misaligned_reg;

    // Only reset clears the PLL lock flag.
    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(lock_reg))
        else $error("PLL lock flag cleared without reset");

    // A committed store marks its word valid.
    a_store_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && wr_en) |=> valid_reg[$past(idx)])
        else $error("stored word not marked valid");

    // A misaligned access never changes state.
    a_misaligned_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        is_misaligned |-> (!wr_en && !lock_set && !pwr_wr))
        else $error("misaligned access has a side effect");

endmodule

@@ rtl/core/display_serial_link_register_block_top.sv @@
// Register block of a display serial link: one 32-bit word access per request.
// A request is captured with its registered RAM read, then committed once the output is free.
// One access at a time: a new request is taken only after the last one is committed.
// Reset clears the per-word valid bits and the PLL flags at once; no clearing pass.
// Depends on dslr_pkg, dslr_if, dslr_ctrl and dslr_datapath.
module display_serial_link_register_block_top (
    input  logic       clk,
    input  logic       rst_n,
    dslr_req_if.sink   req,
    dslr_rsp_if.source rsp
);
    import dslr_pkg::*;

    dslr_cmd_t cmd;

    // Controller.
    dslr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Datapath.
    dslr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req.req_type),
        .byte_offset (req.byte_offset),
        .write_data  (req.write_data),
        .read_data   (rsp.read_data),
        .misaligned  (rsp.misaligned)
    );

endmodule

@@ sim/tb_display_serial_link_register_block_top.sv @@
`timescale 1ns / 100ps
// Testbench for the display serial link register block: random and directed bus words,
// an in-order response scoreboard and a cycle-level watchdog.
// Depends on dslr_pkg, dslr_if and display_serial_link_register_block_top.
module tb_display_serial_link_register_block_top;

    import dslr_pkg::*;

    // Power command and power status fields of the clock control word.
    localparam logic [DATA_W-1:0] PWR_CMD_MASK    = 32'hC000_0000;
    localparam logic [DATA_W-1:0] PWR_STATUS_MASK = 32'h3000_0000;
    localparam logic [6:0]        CLKCTRL_IDX     = OFF_CLKCTRL[8:2];
    localparam int                RANDOM_WORDS    = 1500;
    localparam int                IDLE_LIMIT      = 2000;
    localparam int                HOLD_CYCLES     = 300;

    typedef struct packed
    {
        logic                req_type;
        logic [OFFSET_W-1:0] byte_offset;
        logic [DATA_W-1:0]   write_data;
    } bus_access_t;

    typedef struct packed
    {
        logic [DATA_W-1:0] read_data;
        logic              misaligned;
    } bus_result_t;

    logic clk;
    logic rst_n;

    dslr_req_if req_ch ();
    dslr_rsp_if rsp_ch ();

    display_serial_link_register_block_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the register contents.
    logic [DATA_W-1:0] proto_mem [PROTOCOL_WORDS];
    logic [DATA_W-1:0] phy_mem   [SUB_WORDS];
    logic [DATA_W-1:0] pll_mem   [SUB_WORDS];
    logic              lock_mirror;

    bus_access_t pending_accesses [$];
    bus_result_t expected_responses [$];
    bus_access_t next_access;
    bus_access_t seen_access;
    bus_result_t want_resp;

    int unsigned words_planned;
    int unsigned words_accepted;
    int unsigned error_count;
    int unsigned idle_cycles;

    bit          word_sent;
    bit          word_live;
    bit          send_calm;
    int unsigned send_gap;
    bit          resp_taken;
    bit          resp_calm;
    bit          resp_hold;
    int unsigned resp_stall;

    always #5 clk = ~clk;

    // Apply one bus word to the mirror and return the response it should produce.
    function automatic bus_result_t apply_bus_access(bus_access_t acc);
        bus_result_t         res;
        logic [OFFSET_W-1:0] off;
        logic [DATA_W-1:0]   wd;
        off = acc.byte_offset;
        wd = acc.write_data;
        res.read_data = '0;
        res.misaligned = 1'b0;
        if (off[1:0] != 2'b00)
        begin
            res.misaligned = 1'b1;
        end
        else if (acc.req_type == REQ_WRITE)
        begin
            if (off < PHY_START)
            begin
                case (off)
                    // Revision and system status are read-only.
                    OFF_REVISION, OFF_SYSSTATUS: ;
                    OFF_SYSCONFIG: proto_mem[off[8:2]] = wd & ~SOFT_RESET_MASK;
                    OFF_IRQSTATUS: proto_mem[off[8:2]] = proto_mem[off[8:2]] & ~wd;
                    OFF_CLKCTRL:
                        proto_mem[off[8:2]] = (wd & ~PWR_STATUS_MASK) | ((wd & PWR_CMD_MASK) >> 2);
                    default: proto_mem[off[8:2]] = wd;
                endcase
            end
            else if (off < PLL_START)
            begin
                phy_mem[off[7:2]] = wd;
            end
            else if (off == OFF_PLL_GO)
            begin
                if (wd[0])
                    lock_mirror = 1'b1;
            end
            else if (off != OFF_PLL_STATUS)
            begin
                pll_mem[off[7:2]] = wd;
            end
        end
        else
        begin
            if (off < PHY_START)
                res.read_data = proto_mem[off[8:2]];
            else if (off < PLL_START)
                res.read_data = phy_mem[off[7:2]];
            else if (off == OFF_PLL_STATUS)
                res.read_data = {30'd0, lock_mirror, |(proto_mem[CLKCTRL_IDX] & PWR_STATUS_MASK)};
            else if (off != OFF_PLL_GO)
                res.read_data = pll_mem[off[7:2]];
        end
        return res;
    endfunction

    task automatic queue_access(input logic kind, input logic [OFFSET_W-1:0] off,
                                input logic [DATA_W-1:0] data);
        bus_access_t acc;
        acc.req_type = kind;
        acc.byte_offset = off;
        acc.write_data = data;
        pending_accesses.push_back(acc);
    endtask

    task automatic report_error(input string what, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
        error_count++;
        if (error_count <= 10)
            $display("ERROR %s: expected %h, got %h at %0t ns", what, want, got, $realtime);
    endtask

    // Offsets are biased toward the special words, a small set of reused words and
    // misaligned addresses so that reads often return earlier writes.
    function automatic logic [OFFSET_W-1:0] pick_offset();
        logic [OFFSET_W-1:0] off;
        int unsigned         pick;
        pick = $urandom_range(0, 15);
        off = {8'($urandom_range(0, 255)), 2'b00};
        if (pick < 2)
        begin
            off[1:0] = 2'($urandom_range(1, 3));
        end
        else if (pick < 6)
        begin
            case ($urandom_range(0, 7))
                0: off = OFF_REVISION;
                1: off = OFF_SYSCONFIG;
                2: off = OFF_SYSSTATUS;
                3: off = OFF_IRQSTATUS;
                4: off = OFF_CLKCTRL;
                5: off = OFF_PLL_STATUS;
                6: off = OFF_PLL_GO;
                default: off = PLL_START;
            endcase
        end
        else if (pick < 10)
        begin
            off[9:8] = 2'($urandom_range(0, 3));
            off[7:4] = 4'h3;
        end
        return off;
    endfunction

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Request driver: one word at a time, random gaps between words.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (word_sent)
            begin
                word_sent = 1'b0;
                word_live = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    send_calm = !send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, 8);
            end
            if (!word_live)
            begin
                if (send_gap != 0 || pending_accesses.size() == 0)
                begin
                    if (send_gap != 0)
                        send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    next_access = pending_accesses.pop_front();
                    req_ch.req_type <= next_access.req_type;
                    req_ch.byte_offset <= next_access.byte_offset;
                    req_ch.write_data <= next_access.write_data;
                    req_ch.valid <= 1'b1;
                    word_live = 1'b1;
                end
            end
        end
    end

    // Accepted requests update the mirror and queue their expected response.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            seen_access.req_type = req_ch.req_type;
            seen_access.byte_offset = req_ch.byte_offset;
            seen_access.write_data = req_ch.write_data;
            expected_responses.push_back(apply_bus_access(seen_access));
            words_accepted++;
            word_sent = 1'b1;
        end
    end

    // Response ready: random stall per word, plus the long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (resp_taken)
            begin
                resp_taken = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    resp_calm = !resp_calm;
                resp_stall = resp_calm ? 0 : $urandom_range(0, 8);
            end
            if (resp_stall != 0)
            begin
                resp_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= !resp_hold;
            end
        end
    end

    // Response checker against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            resp_taken = 1'b1;
            if (expected_responses.size() == 0)
            begin
                report_error("unexpected response word", '0, rsp_ch.read_data);
            end
            else
            begin
                want_resp = expected_responses.pop_front();
                if (rsp_ch.read_data !== want_resp.read_data)
                    report_error("read_data", want_resp.read_data, rsp_ch.read_data);
                if (rsp_ch.misaligned !== want_resp.misaligned)
                    report_error("misaligned", {31'd0, want_resp.misaligned},
                                 {31'd0, rsp_ch.misaligned});
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired with %0d responses outstanding",
                     expected_responses.size());
            $display("tb_display_serial_link_register_block_top: errors");
            $finish;
        end
    end

    // Long receiver hold-off while requests keep coming, so the block backs up.
    initial
    begin
        resp_hold = 1'b0;
        wait (words_accepted >= 500);
        @(posedge clk);
        resp_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        resp_hold = 1'b0;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_READ;
        req_ch.byte_offset = '0;
        req_ch.write_data = '0;
        rsp_ch.ready = 1'b0;

        for (int i = 0; i < PROTOCOL_WORDS; i++)
            proto_mem[i] = '0;
        for (int i = 0; i < SUB_WORDS; i++)
        begin
            phy_mem[i] = '0;
            pll_mem[i] = '0;
        end
        proto_mem[SYSSTATUS_IDX] = SYSSTATUS_RESET;
        lock_mirror = 1'b0;

        // Reset values and the read-only words.
        queue_access(REQ_READ, OFF_REVISION, '0);
        queue_access(REQ_READ, OFF_SYSSTATUS, '1);
        queue_access(REQ_WRITE, OFF_REVISION, '1);
        queue_access(REQ_READ, OFF_REVISION, '0);
        queue_access(REQ_WRITE, OFF_SYSSTATUS, '0);
        queue_access(REQ_READ, OFF_SYSSTATUS, '0);
        // Soft reset bit clears itself; interrupt status is write-one-to-clear.
        queue_access(REQ_WRITE, OFF_SYSCONFIG, '1);
        queue_access(REQ_READ, OFF_SYSCONFIG, '0);
        queue_access(REQ_WRITE, OFF_IRQSTATUS, '1);
        queue_access(REQ_READ, OFF_IRQSTATUS, '0);
        // Power command mirrored into power status, seen in PLL status.
        queue_access(REQ_WRITE, OFF_CLKCTRL, 32'hC000_0000);
        queue_access(REQ_READ, OFF_CLKCTRL, '0);
        queue_access(REQ_READ, OFF_PLL_STATUS, '0);
        // A misaligned or even GO write must not lock the PLL; an odd one does.
        queue_access(REQ_WRITE, OFF_PLL_GO + 10'd1, 32'h0000_0001);
        queue_access(REQ_WRITE, OFF_PLL_GO, 32'hFFFF_FFFE);
        queue_access(REQ_READ, OFF_PLL_STATUS, '0);
        queue_access(REQ_WRITE, OFF_PLL_GO, 32'h0000_0001);
        queue_access(REQ_READ, OFF_PLL_GO, '1);
        queue_access(REQ_WRITE, OFF_PLL_STATUS, '1);
        queue_access(REQ_WRITE, OFF_CLKCTRL, 32'h3FFF_FFFF);
        queue_access(REQ_READ, OFF_PLL_STATUS, '0);
        // Region edges and misaligned reads.
        queue_access(REQ_WRITE, PHY_START - 10'd4, '1);
        queue_access(REQ_READ, PHY_START - 10'd4, '0);
        queue_access(REQ_WRITE, PHY_START, 32'h5A5A_5A5A);
        queue_access(REQ_READ, PHY_START, '0);
        queue_access(REQ_WRITE, 10'h3FC, 32'hA5A5_A5A5);
        queue_access(REQ_READ, 10'h3FC, '0);
        queue_access(REQ_READ, 10'h3FF, '0);

        for (int i = 0; i < RANDOM_WORDS; i++)
            queue_access(($urandom_range(0, 1) == 0) ? REQ_READ : REQ_WRITE,
                         pick_offset(), pick_data());
        words_planned = pending_accesses.size();

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        wait (words_accepted == words_planned);
        wait (expected_responses.size() == 0);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb_display_serial_link_register_block_top: clean");
        else
            $display("tb_display_serial_link_register_block_top: errors");
        $finish;
    end

endmodule

@@ display_serial_link_register_block_top.f @@
rtl/core/dslr_pkg.sv
rtl/core/dslr_if.sv
rtl/core/dslr_ram.sv
rtl/core/dslr_ctrl.sv
rtl/core/dslr_datapath.sv
rtl/core/display_serial_link_register_block_top.sv
sim/tb_display_serial_link_register_block_top.sv
